// File: src/mutex_with_fifo_handoff_defines.svh
// assertion macros for the mutex with fifo handoff block
`ifndef MUTEX_WITH_FIFO_HANDOFF_DEFINES_SVH
`define MUTEX_WITH_FIFO_HANDOFF_DEFINES_SVH
`ifndef SYNTH
`define MWFH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MWFH_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MWFH_ASSERT(label, prop, msg)
`define MWFH_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: src/mwfh_pkg.sv
// shared types and codes for the mutex with fifo handoff block
`default_nettype none
package mwfh_pkg;

  localparam int TASK_W = 4;
  localparam int MODE_W = 2;

  typedef logic [TASK_W-1:0] task_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOCK   = 2'd0,
    MODE_TRY    = 2'd1,
    MODE_UNLOCK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    STAT_GRANTED    = 3'd0,
    STAT_TRY_FAILED = 3'd1,
    STAT_QUEUED     = 3'd2,
    STAT_RELEASED   = 3'd3,
    STAT_HANDED     = 3'd4,
    STAT_IGNORED    = 3'd5,
    STAT_FULL       = 3'd6
  } status_t;

  typedef struct packed {
    task_t   owner_task;
    logic    owner_valid;
    logic    is_locked;
    task_t   woken_task;
    logic    woken_valid;
    status_t status;
  } result_t;

endpackage
`default_nettype wire

// File: src/mwfh_qmem.sv
// wait queue storage, one write and one registered read port
`default_nettype none
module mwfh_qmem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire mwfh_pkg::task_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output mwfh_pkg::task_t      rd_data
);
  import mwfh_pkg::*;

  task_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: src/mwfh_ctrl.sv
// request sequencer: lock state, queue pointers and result register
`default_nettype none
`include "mutex_with_fifo_handoff_defines.svh"
module mwfh_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PTR_W       = 4,
  parameter int CNT_W       = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_mode,
  input  wire mwfh_pkg::task_t       in_task,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output mwfh_pkg::result_t          out_res,
  output logic                       wr_en,
  output logic [PTR_W-1:0]           wr_addr,
  output mwfh_pkg::task_t            wr_data,
  output logic [PTR_W-1:0]           rd_addr,
  input  wire mwfh_pkg::task_t       rd_data
);
  import mwfh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t           state;
  logic [1:0]       req_mode;
  task_t            req_task;
  logic             lock_flag, lock_flag_next;
  task_t            owner, owner_next;
  logic             owner_present, owner_present_next;
  logic [PTR_W-1:0] fifo_head, fifo_head_next;
  logic [PTR_W-1:0] fifo_tail, fifo_tail_next;
  logic [CNT_W-1:0] fifo_count, fifo_count_next;
  logic             commit;
  logic             full;
  result_t          res_next;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_EXEC) && (!out_valid || out_ready);
  assign full     = (fifo_count == CNT_W'(QUEUE_DEPTH));
  assign rd_addr  = fifo_head;
  assign wr_addr  = fifo_tail;
  assign wr_data  = req_task;

  always_comb begin
    lock_flag_next     = lock_flag;
    owner_next         = owner;
    owner_present_next = owner_present;
    fifo_head_next     = fifo_head;
    fifo_tail_next     = fifo_tail;
    fifo_count_next    = fifo_count;
    wr_en              = 1'b0;
    res_next.status      = STAT_IGNORED;
    res_next.woken_valid = 1'b0;
    res_next.woken_task  = '0;
    case (req_mode)
      MODE_LOCK, MODE_TRY: begin
        if (!lock_flag) begin
          lock_flag_next     = 1'b1;
          owner_next         = req_task;
          owner_present_next = 1'b1;
          res_next.status    = STAT_GRANTED;
        end else if (req_mode == MODE_TRY) begin
          res_next.status = STAT_TRY_FAILED;
        end else if (full) begin
          res_next.status = STAT_FULL;
        end else begin
          wr_en           = commit;
          fifo_tail_next  = next_slot(fifo_tail);
          fifo_count_next = fifo_count + CNT_W'(1);
          res_next.status = STAT_QUEUED;
        end
      end
      MODE_UNLOCK: begin
        if (lock_flag && owner_present && owner == req_task) begin
          if (fifo_count != '0) begin
            fifo_head_next       = next_slot(fifo_head);
            fifo_count_next      = fifo_count - CNT_W'(1);
            owner_next           = rd_data;
            owner_present_next   = 1'b1;
            lock_flag_next       = 1'b1;
            res_next.woken_valid = 1'b1;
            res_next.woken_task  = rd_data;
            res_next.status      = STAT_HANDED;
          end else begin
            lock_flag_next     = 1'b0;
            owner_next         = '0;
            owner_present_next = 1'b0;
            res_next.status    = STAT_RELEASED;
          end
        end
      end
      default: begin
        res_next.status = STAT_IGNORED;
      end
    endcase
    res_next.is_locked   = lock_flag_next;
    res_next.owner_valid = owner_present_next;
    res_next.owner_task  = owner_present_next ? owner_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lock_flag     <= 1'b0;
      owner         <= '0;
      owner_present <= 1'b0;
      fifo_head     <= '0;
      fifo_tail     <= '0;
      fifo_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        lock_flag     <= lock_flag_next;
        owner         <= owner_next;
        owner_present <= owner_present_next;
        fifo_head     <= fifo_head_next;
        fifo_tail     <= fifo_tail_next;
        fifo_count    <= fifo_count_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_mode <= in_mode;
      req_task <= in_task;
    end
    if (commit) begin
      out_res <= res_next;
    end
  end

  `MWFH_ASSERT(a_cnt_range, fifo_count <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `MWFH_ASSERT(a_lock_owner, lock_flag == owner_present, "lock flag and owner disagree")
  `MWFH_ASSERT(a_empty_ptr, fifo_count == '0 |-> fifo_head == fifo_tail, "empty queue with split pointers")
  `MWFH_ASSERT(a_woken, out_valid |-> (out_res.woken_valid == (out_res.status == STAT_HANDED)), "woken flag without handover")
  `MWFH_ASSERT_RST(a_rst_clear, rst |=> !out_valid && lock_flag == 1'b0, "reset left state behind")

endmodule
`default_nettype wire

// File: src/mutex_with_fifo_handoff.sv
// Hardware mutex with a first-in first-out queue of waiting tasks. Each
// request names a mode (lock, trylock, unlock) and a task; one result per
// request reports the outcome, any task handed the lock, and the lock flag
// and owner afterwards. A request is taken in the idle state, as the wait
// queue head is read through the memory's registered read port, and is
// decided and written back in the execute state. Only one request is in
// flight; a result register lets the next be taken while a result waits.
`default_nettype none
module mutex_with_fifo_handoff #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // task_id[3:0], zero fill
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // status[2:0], woken_valid, woken_task[3:0],
                                      // is_locked, owner_valid, owner_task[3:0], zero fill
);
  import mwfh_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          res;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  task_t            wr_data;
  logic [PTR_W-1:0] rd_addr;
  task_t            rd_data;

  mwfh_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_task   (s_tdata[TASK_W-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  mwfh_qmem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_qmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign m_tdata = {2'b00, res.owner_task, res.owner_valid, res.is_locked,
                    res.woken_task, res.woken_valid, res.status};

endmodule
`default_nettype wire

// File: test/mutex_with_fifo_handoff_tb.sv
// testbench for the mutex with fifo handoff block: directed table, random requests, predictor
`timescale 1ns / 100ps
module mutex_with_fifo_handoff_tb;
  import mwfh_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUEUE_LIMIT = 16;
  localparam int NUM_PHASES = 8;
  localparam int COUNTED_PER_PHASE = 245;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0] kind;
    task_t      tid;
    bit         typed;
    result_t    want;
  } req_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // task_id[3:0], zero fill
  logic [1:0]  s_tuser;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // status[2:0], woken_valid, woken_task[3:0],
                          // is_locked, owner_valid, owner_task[3:0], zero fill

  // predictor state
  bit       lock_held;
  task_t    owner_id;
  bit       owner_known;
  task_t    waiters[$];

  result_t  expected_results[$];
  req_row_t directed_rows[$];
  int       failures;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_off_req;
  int       cycle_count;

  mutex_with_fifo_handoff dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic result_t outcome(input status_t st, input logic wv, input task_t wt,
                                      input logic lk, input logic ov, input task_t ot);
    result_t r;
    r.status      = st;
    r.woken_valid = wv;
    r.woken_task  = wt;
    r.is_locked   = lk;
    r.owner_valid = ov;
    r.owner_task  = ot;
    return r;
  endfunction

  function automatic result_t predict_request(input logic [1:0] kind, input task_t tid);
    result_t r;
    r = '0;
    r.status = STAT_IGNORED;
    case (kind)
      MODE_LOCK, MODE_TRY: begin
        if (!lock_held) begin
          lock_held   = 1'b1;
          owner_id    = tid;
          owner_known = 1'b1;
          r.status    = STAT_GRANTED;
        end else if (kind == MODE_TRY) begin
          r.status = STAT_TRY_FAILED;
        end else if (waiters.size() >= QUEUE_LIMIT) begin
          r.status = STAT_FULL;
        end else begin
          waiters.push_back(tid);
          r.status = STAT_QUEUED;
        end
      end
      MODE_UNLOCK: begin
        if (lock_held && owner_known && owner_id == tid) begin
          if (waiters.size() != 0) begin
            r.woken_task  = waiters.pop_front();
            r.woken_valid = 1'b1;
            owner_id      = r.woken_task;
            r.status      = STAT_HANDED;
          end else begin
            lock_held   = 1'b0;
            owner_id    = '0;
            owner_known = 1'b0;
            r.status    = STAT_RELEASED;
          end
        end
      end
      default: ;
    endcase
    r.is_locked   = lock_held;
    r.owner_valid = owner_known;
    r.owner_task  = owner_known ? owner_id : '0;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] kind, input task_t tid, input bit typed,
                         input result_t want);
    req_row_t row;
    row.kind  = kind;
    row.tid   = tid;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic offer_request(input logic [1:0] kind, input task_t tid, input bit typed,
                               input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0000, tid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_request(kind, tid);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic flag_field(input string field, input int want, input int got);
    $display("%0t %s expected %0d actual %0d", $time, field, want, got);
    failures++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[13:0]);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result transfer, expected none actual %h", $time, m_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (want.status !== got.status) flag_field("status", want.status, got.status);
        if (want.woken_valid !== got.woken_valid)
          flag_field("woken_valid", want.woken_valid, got.woken_valid);
        if (want.woken_task !== got.woken_task)
          flag_field("woken_task", want.woken_task, got.woken_task);
        if (want.is_locked !== got.is_locked)
          flag_field("is_locked", want.is_locked, got.is_locked);
        if (want.owner_valid !== got.owner_valid)
          flag_field("owner_valid", want.owner_valid, got.owner_valid);
        if (want.owner_task !== got.owner_task)
          flag_field("owner_task", want.owner_task, got.owner_task);
      end
    end
  end

  // receiver
  initial begin
    int hold_cycles;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_off_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // sender
  initial begin
    logic [1:0] kind;
    task_t tid;
    int counted;
    int lock_pct;
    int pick;
    failures       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    lock_held      = 1'b0;
    owner_id       = '0;
    owner_known    = 1'b0;
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    s_tuser        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_row(MODE_UNLOCK, 4'd0, 1'b1,
            outcome(STAT_IGNORED, 1'b0, 4'd0, 1'b0, 1'b0, 4'd0));
    add_row(MODE_UNUSED, 4'd15, 1'b1,
            outcome(STAT_IGNORED, 1'b0, 4'd0, 1'b0, 1'b0, 4'd0));
    add_row(MODE_TRY, 4'd15, 1'b1,
            outcome(STAT_GRANTED, 1'b0, 4'd0, 1'b1, 1'b1, 4'd15));
    add_row(MODE_TRY, 4'd0, 1'b1,
            outcome(STAT_TRY_FAILED, 1'b0, 4'd0, 1'b1, 1'b1, 4'd15));
    add_row(MODE_LOCK, 4'd15, 1'b1,
            outcome(STAT_QUEUED, 1'b0, 4'd0, 1'b1, 1'b1, 4'd15));
    for (int i = 0; i < QUEUE_LIMIT - 1; i++) add_row(MODE_LOCK, task_t'(i), 1'b0, '0);
    add_row(MODE_LOCK, 4'd10, 1'b1,
            outcome(STAT_FULL, 1'b0, 4'd0, 1'b1, 1'b1, 4'd15));
    add_row(MODE_UNLOCK, 4'd0, 1'b1,
            outcome(STAT_IGNORED, 1'b0, 4'd0, 1'b1, 1'b1, 4'd15));
    add_row(MODE_UNLOCK, 4'd15, 1'b1,
            outcome(STAT_HANDED, 1'b1, 4'd15, 1'b1, 1'b1, 4'd15));
    add_row(MODE_UNLOCK, 4'd15, 1'b0, '0);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].kind, directed_rows[i].tid, directed_rows[i].typed,
                    directed_rows[i].want);
    wait_for_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (phase == 4) hold_off_req = 1'b1;
      lock_pct = $urandom_range(20, 50);
      counted = 0;
      while (counted < COUNTED_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        tid  = task_t'($urandom_range(0, 15));
        if (pick < lock_pct) begin
          kind = MODE_LOCK;
        end else if (pick < lock_pct + 15) begin
          kind = MODE_TRY;
        end else if (pick < 90) begin
          kind = MODE_UNLOCK;
          if (owner_known) tid = owner_id;
        end else if (pick < 96) begin
          kind = MODE_UNLOCK;
        end else begin
          kind = MODE_UNUSED;
        end
        offer_request(kind, tid, 1'b0, '0);
        counted++;
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
